### rtl/core/e2c_pkg.sv
`default_nettype none

package e2c_pkg;

    localparam logic [31:0] LAST_SECOND   = 32'd4102444799;
    localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [7:0]  BASE_YOFF     = 8'd70;
    localparam logic [11:0] CENTURY_BASE  = 12'd1900;
    localparam logic [15:0] DAYS_COMMON   = 16'd365;
    localparam logic [15:0] DAYS_LEAP     = 16'd366;
    localparam logic [3:0]  MONTH_JAN     = 4'd0;
    localparam logic [3:0]  MONTH_MAR     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd11;
    localparam logic [2:0]  WEEK_LEN      = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPLIT,
        ST_MONTH,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step_div;
        logic step_split;
        logic step_month;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic year_done;
        logic time_done;
        logic month_done;
    } t_dp_sts;

    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] week_offset(input logic [3:0] idx);
        logic [2:0] off;
        case (idx)
            4'd0:    off = 3'd0;
            4'd1:    off = 3'd3;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd6;
            4'd4:    off = 3'd1;
            4'd5:    off = 3'd4;
            4'd6:    off = 3'd6;
            4'd7:    off = 3'd2;
            4'd8:    off = 3'd5;
            4'd9:    off = 3'd0;
            4'd10:   off = 3'd3;
            4'd11:   off = 3'd5;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

### rtl/core/e2c_datapath.sv
`default_nettype none

module e2c_datapath
    import e2c_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [31:0] i_epoch_seconds,
    output t_dp_sts          o_sts,
    output logic [11:0]      o_cal_year,
    output logic [3:0]       o_cal_month,
    output logic [4:0]       o_cal_day,
    output logic [4:0]       o_clock_hour,
    output logic [5:0]       o_clock_minute,
    output logic [5:0]       o_clock_second,
    output logic [2:0]       o_week_day,
    output logic             o_range_error
);

    logic [31:0] r_dvd;
    logic [16:0] r_rem;
    logic [15:0] r_quot;
    logic        r_div_step;
    logic [7:0]  r_yoff;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [3:0]  r_month;
    logic        r_flag;

    logic [11:0] r_out_year;
    logic [3:0]  r_out_month;
    logic [4:0]  r_out_day;
    logic [4:0]  r_out_hour;
    logic [5:0]  r_out_min;
    logic [5:0]  r_out_sec;
    logic [2:0]  r_out_wday;
    logic        r_out_flag;

    logic [50:0] w_recip_prod;
    logic [15:0] w_quot;
    logic [33:0] w_day_secs;
    logic [15:0] w_days;
    logic        w_leap;
    logic [15:0] w_ylen;
    logic [4:0]  w_mlen;
    logic [4:0]  w_day;
    logic        w_adj;
    logic [8:0]  w_wsum;
    logic [4:0]  w_fold1;
    logic [3:0]  w_fold2;
    logic [2:0]  w_wday;

    always_comb begin
        // The day count is the seconds over 128 times a rounded-up reciprocal of 675,
        // which is exact for every 25-bit operand.
        w_recip_prod = r_dvd[31:7] * DAY_RECIP;
        w_quot       = w_recip_prod[50:35];
        w_day_secs   = r_quot * SECS_PER_DAY;
        w_days   = r_dvd[15:0];
        w_leap   = (r_yoff[1:0] == 2'b00);
        w_ylen   = w_leap ? DAYS_LEAP : DAYS_COMMON;
        w_mlen   = month_len(r_month, w_leap);
        w_day    = w_days[4:0] + 5'd1;
        w_adj    = w_leap && (r_month < MONTH_MAR);
        w_wsum   = 9'(r_yoff) + 9'(r_yoff[7:2]) + 9'(w_day) + 9'(week_offset(r_month))
                 - 9'(w_adj);
        // Powers of eight are one modulo seven, so octal digits may be summed.
        w_fold1  = 5'(w_wsum[8:6]) + 5'(w_wsum[5:3]) + 5'(w_wsum[2:0]);
        w_fold2  = 4'(w_fold1[4:3]) + 4'(w_fold1[2:0]);
        w_wday   = (w_fold2 >= 4'(WEEK_LEN)) ? 3'(w_fold2 - 4'(WEEK_LEN)) : w_fold2[2:0];
    end

    always_comb begin
        o_sts.div_last   = r_div_step;
        o_sts.year_done  = (w_days < w_ylen);
        o_sts.time_done  = (r_rem < SECS_PER_MIN);
        o_sts.month_done = (w_days < 16'(w_mlen)) || (r_month == MONTH_DEC);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_epoch_seconds > LAST_SECOND) begin
                r_dvd  <= LAST_SECOND;
                r_flag <= 1'b1;
            end else begin
                r_dvd  <= i_epoch_seconds;
                r_flag <= 1'b0;
            end
            r_rem      <= '0;
            r_div_step <= 1'b0;
            r_yoff     <= BASE_YOFF;
            r_hour     <= '0;
            r_min      <= '0;
            r_month    <= MONTH_JAN;
        end else if (i_cmd.step_div) begin
            if (!r_div_step) begin
                r_quot     <= w_quot;
                r_div_step <= 1'b1;
            end else begin
                r_dvd <= {16'd0, r_quot};
                r_rem <= 17'(r_dvd - w_day_secs[31:0]);
            end
        end else if (i_cmd.step_split) begin
            if (!o_sts.year_done) begin
                r_dvd  <= {16'd0, w_days - w_ylen};
                r_yoff <= r_yoff + 8'd1;
            end
            if (r_rem >= SECS_PER_HOUR) begin
                r_rem  <= r_rem - SECS_PER_HOUR;
                r_hour <= r_hour + 5'd1;
            end else if (r_rem >= SECS_PER_MIN) begin
                r_rem <= r_rem - SECS_PER_MIN;
                r_min <= r_min + 6'd1;
            end
        end else if (i_cmd.step_month) begin
            if (!o_sts.month_done) begin
                r_dvd   <= {16'd0, w_days - 16'(w_mlen)};
                r_month <= r_month + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_year  <= 12'(r_yoff) + CENTURY_BASE;
            r_out_month <= r_month + 4'd1;
            r_out_day   <= w_day;
            r_out_hour  <= r_hour;
            r_out_min   <= r_min;
            r_out_sec   <= r_rem[5:0];
            r_out_wday  <= w_wday;
            r_out_flag  <= r_flag;
        end
    end

    assign o_cal_year     = r_out_year;
    assign o_cal_month    = r_out_month;
    assign o_cal_day      = r_out_day;
    assign o_clock_hour   = r_out_hour;
    assign o_clock_minute = r_out_min;
    assign o_clock_second = r_out_sec;
    assign o_week_day     = r_out_wday;
    assign o_range_error  = r_out_flag;

endmodule

`default_nettype wire

### rtl/core/e2c_controller.sv
`default_nettype none

module e2c_controller
    import e2c_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step_div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                o_cmd.step_split = 1'b1;
                if (i_sts.year_done && i_sts.time_done) begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                o_cmd.step_month = 1'b1;
                if (i_sts.month_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/core/epoch_seconds_to_calendar_core.sv
//  Channel   Direction  Handshake             Payload
//  request   in         i_valid / o_stall     i_epoch_seconds
//  result    out        o_valid / i_stall     o_cal_*, o_clock_*, o_week_day, o_range_error
//
//  A request runs the day count (quotient, then remainder), then a year subtraction per
//  whole year (up to 129, with the time of day split alongside) and a last check, a month
//  subtraction per whole month (up to 11) and a last check, and the result register load,
//  which waits while an earlier result is held. The year subtraction loop is the longest.
//  Reset is synchronous and clears the controller; the result register stays until taken.
//  A new request is taken while an earlier result still waits under i_stall.
`default_nettype none

module epoch_seconds_to_calendar_core
    import e2c_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [11:0]      o_cal_year,
    output logic [3:0]       o_cal_month,
    output logic [4:0]       o_cal_day,
    output logic [4:0]       o_clock_hour,
    output logic [5:0]       o_clock_minute,
    output logic [5:0]       o_clock_second,
    output logic [2:0]       o_week_day,
    output logic             o_range_error
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    e2c_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    e2c_datapath u_dp (
        .i_clk           (i_clk),
        .i_cmd           (w_cmd),
        .i_epoch_seconds (i_epoch_seconds),
        .o_sts           (w_sts),
        .o_cal_year      (o_cal_year),
        .o_cal_month     (o_cal_month),
        .o_cal_day       (o_cal_day),
        .o_clock_hour    (o_clock_hour),
        .o_clock_minute  (o_clock_minute),
        .o_clock_second  (o_clock_second),
        .o_week_day      (o_week_day),
        .o_range_error   (o_range_error)
    );

endmodule

`default_nettype wire

### rtl/core/e2c_checker.sv
`default_nettype none

module e2c_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [11:0] o_cal_year,
    input wire logic [3:0]  o_cal_month,
    input wire logic [4:0]  o_cal_day,
    input wire logic [4:0]  o_clock_hour,
    input wire logic [5:0]  o_clock_minute,
    input wire logic [5:0]  o_clock_second,
    input wire logic [2:0]  o_week_day,
    input wire logic        o_range_error
);

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cal_year >= 12'd1970) && (o_cal_year <= 12'd2099)
                 && (o_cal_month >= 4'd1) && (o_cal_month <= 4'd12)
                 && (o_cal_day >= 5'd1) && (o_clock_hour <= 5'd23)
                 && (o_clock_minute <= 6'd59) && (o_clock_second <= 6'd59)
                 && (o_week_day <= 3'd6))
        else $error("result field out of range");

    a_saturated_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_cal_year == 12'd2099) && (o_cal_month == 4'd12)
                 && (o_cal_day == 5'd31) && (o_clock_hour == 5'd23)
                 && (o_clock_minute == 6'd59) && (o_clock_second == 6'd59)
                 && (o_week_day == 3'd4))
        else $error("range error without the last representable second");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while the previous one is in progress");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_cal_year) && $stable(o_cal_month)
                 && $stable(o_cal_day) && $stable(o_clock_hour) && $stable(o_clock_minute)
                 && $stable(o_clock_second) && $stable(o_week_day) && $stable(o_range_error))
        else $error("stalled result changed");

endmodule

bind epoch_seconds_to_calendar_core e2c_checker u_e2c_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_cal_year     (o_cal_year),
    .o_cal_month    (o_cal_month),
    .o_cal_day      (o_cal_day),
    .o_clock_hour   (o_clock_hour),
    .o_clock_minute (o_clock_minute),
    .o_clock_second (o_clock_second),
    .o_week_day     (o_week_day),
    .o_range_error  (o_range_error)
);

`default_nettype wire

### tb/calendar_result_checker.sv
`default_nettype none

module calendar_result_checker
    import e2c_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [31:0] i_epoch_seconds,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [11:0] o_cal_year,
    input  wire logic [3:0]  o_cal_month,
    input  wire logic [4:0]  o_cal_day,
    input  wire logic [4:0]  o_clock_hour,
    input  wire logic [5:0]  o_clock_minute,
    input  wire logic [5:0]  o_clock_second,
    input  wire logic [2:0]  o_week_day,
    input  wire logic        o_range_error,
    output int               fail_count,
    output int               pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        logic        saturated;
    } t_calendar;

    localparam int unsigned WEEK_SHIFT [0:11] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
    localparam int unsigned MONTH_DAYS [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    t_calendar expected_dates [$];
    t_calendar got;
    t_calendar want;

    function automatic bit is_leap(input int unsigned year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function automatic t_calendar to_calendar(input logic [31:0] epoch);
        t_calendar   c;
        logic [31:0] secs;
        int unsigned days;
        int unsigned sod;
        int unsigned year;
        int unsigned month;
        int unsigned mlen;
        int unsigned yl;
        int unsigned acc;
        secs = epoch;
        c.saturated = 1'b0;
        if (secs > LAST_SECOND) begin
            secs = LAST_SECOND;
            c.saturated = 1'b1;
        end
        days = secs / 86400;
        sod  = secs % 86400;
        year = 1970;
        while (days >= (is_leap(year) ? 366 : 365)) begin
            days = days - (is_leap(year) ? 366 : 365);
            year++;
        end
        month = 0;
        for (int i = 0; i < 12; i++) begin
            mlen = MONTH_DAYS[i];
            if (i == 1 && is_leap(year)) begin
                mlen = 29;
            end
            if (days < mlen) begin
                break;
            end
            days = days - mlen;
            month++;
        end
        if (month > 11) begin
            month = 11;
        end
        yl = year % 100;
        if (year / 100 > 19) begin
            yl = yl + 100;
        end
        acc = (yl + yl / 4) % 7 + (days + 1) + WEEK_SHIFT[month];
        if (yl % 4 == 0 && month < 2) begin
            acc = acc - 1;
        end
        c.year   = year[11:0];
        c.month  = 4'(month + 1);
        c.day    = 5'(days + 1);
        c.hour   = 5'(sod / 3600);
        c.minute = 6'((sod % 3600) / 60);
        c.second = 6'(sod % 60);
        c.wday   = 3'(acc % 7);
        return c;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1 && o_stall === 1'b0) begin
                expected_dates.push_back(to_calendar(i_epoch_seconds));
            end
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                got = {o_cal_year, o_cal_month, o_cal_day, o_clock_hour, o_clock_minute,
                       o_clock_second, o_week_day, o_range_error};
                if (expected_dates.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with no request waiting: %p", $realtime, got);
                    end
                end else begin
                    want = expected_dates.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch expected %p actual %p", $realtime,
                                     want, got);
                        end
                    end
                end
            end
            pending <= expected_dates.size();
        end
    end

endmodule

`default_nettype wire

### tb/epoch_seconds_to_calendar_core_tb.sv
`default_nettype none

module epoch_seconds_to_calendar_core_tb
    import e2c_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1425;
    localparam int CALM_REQUESTS   = 150;
    localparam int HOLD_AT         = 200;
    localparam int HOLD_CYCLES     = 1000;
    localparam int TAIL_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 1200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        o_stall;
    logic        o_valid;
    logic [11:0] o_cal_year;
    logic [3:0]  o_cal_month;
    logic [4:0]  o_cal_day;
    logic [4:0]  o_clock_hour;
    logic [5:0]  o_clock_minute;
    logic [5:0]  o_clock_second;
    logic [2:0]  o_week_day;
    logic        o_range_error;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit idling_on = 1'b1;
    bit hold_off_request = 1'b0;
    bit hold_off_done = 1'b0;

    logic [31:0] corner_secs [$] = '{
        32'd0, 32'd1, 32'd59, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999, 32'd31536000, 32'd68169600, 32'd68256000, 32'd94521600,
        32'd94607999, 32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
        32'd978307199, 32'd2147483647, 32'd2147483648, 32'd4102358400,
        32'd4102444799, 32'd4102444800, 32'd4102444801, 32'd4294967295
    };

    epoch_seconds_to_calendar_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_epoch_seconds(i_epoch_seconds),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cal_year     (o_cal_year),
        .o_cal_month    (o_cal_month),
        .o_cal_day      (o_cal_day),
        .o_clock_hour   (o_clock_hour),
        .o_clock_minute (o_clock_minute),
        .o_clock_second (o_clock_second),
        .o_week_day     (o_week_day),
        .o_range_error  (o_range_error)
    );

    calendar_result_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_epoch_seconds(i_epoch_seconds),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cal_year     (o_cal_year),
        .o_cal_month    (o_cal_month),
        .o_cal_day      (o_cal_day),
        .o_clock_hour   (o_clock_hour),
        .o_clock_minute (o_clock_minute),
        .o_clock_second (o_clock_second),
        .o_week_day     (o_week_day),
        .o_range_error  (o_range_error),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    function automatic logic [31:0] pick_epoch();
        logic [31:0] day_start;
        day_start = $urandom_range(0, 47481) * 32'd86400;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                return $urandom();
            end
            5, 6, 7: begin
                case ($urandom_range(0, 2))
                    0:       return day_start;
                    1:       return day_start + 32'd86399;
                    default: return day_start + $urandom_range(0, 86399);
                endcase
            end
            8: begin
                return $urandom_range(0, LAST_SECOND);
            end
            default: begin
                return LAST_SECOND - 32'd300 + $urandom_range(0, 600);
            end
        endcase
    endfunction

    task automatic offer_request(input logic [31:0] secs);
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_epoch_seconds <= secs;
        forever begin
            @(posedge i_clk);
            if (o_stall === 1'b0) begin
                break;
            end
        end
    endtask

    initial begin
        @(negedge i_clk);
        forever begin
            if (hold_off_request && !hold_off_done) begin
                i_stall <= 1'b1;
                hold_off_done = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(negedge i_clk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (corner_secs[k]) begin
            offer_request(corner_secs[k]);
        end
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == HOLD_AT) begin
                hold_off_request = 1'b1;
            end
            if (n == RANDOM_REQUESTS - CALM_REQUESTS) begin
                idling_on = 1'b0;
            end
            offer_request(pick_epoch());
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
